### design/xts_pkg.sv
package xts_pkg;

    localparam int BlockWidth = 128;
    localparam int HalfWidth  = 64;
    localparam int CountWidth = 5;
    localparam int FullBytes  = 16;
    localparam int NumRounds  = 10;
    localparam int RoundWidth = 4;
    localparam logic [7:0] GfFeedback = 8'h87;
    localparam logic [7:0] ByteMask   = 8'hFF;

    typedef enum logic [1:0] {
        REG_TWEAK_KEY_HIGH = 2'd0,
        REG_TWEAK_KEY_LOW  = 2'd1,
        REG_DATA_KEY_HIGH  = 2'd2,
        REG_DATA_KEY_LOW   = 2'd3
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TWEAK_START,
        ST_TWEAK_WAIT,
        ST_CHECK,
        ST_DATA_START,
        ST_DATA_WAIT,
        ST_EMIT_HELD,
        ST_EMIT_MAIN,
        ST_EMIT_TAIL,
        ST_EMIT_ERROR,
        ST_FINISH
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;      // latch the input transaction
        logic cipher_tweak; // start tweak encryption
        logic cipher_data;  // start data encryption
        logic load_tweak;   // store tweak from the cipher
        logic store_cipher; // keep data result, double tweak
        logic out_held;     // present held block
        logic out_held_end; // sector end flag on held block
        logic out_main;     // present fresh ciphertext
        logic out_main_end;
        logic out_tail;     // present stolen tail
        logic out_error;
        logic hold_main;    // move fresh ciphertext into the hold register
        logic set_held;
        logic clr_held;
        logic set_sector;
        logic clr_sector;
    } ctrl_t;

    typedef struct packed {
        logic cipher_done;
        logic out_busy;
        logic first;
        logic last;
        logic short_blk;
        logic held_valid;
        logic in_sector;
    } status_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // state byte i lives at bits 8*i+7 : 8*i
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[8*(4*c+i) +: 8] = SBOX[s[8*(4*((c+i)%4)+i) +: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] t);
        logic [127:0] m;
        logic [7:0] a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++) begin
            a0 = t[8*(4*c)   +: 8];
            a1 = t[8*(4*c+1) +: 8];
            a2 = t[8*(4*c+2) +: 8];
            a3 = t[8*(4*c+3) +: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            m[8*(4*c)   +: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            m[8*(4*c+1) +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            m[8*(4*c+2) +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            m[8*(4*c+3) +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return m;
    endfunction

    // next round key in the same byte layout; word c holds bytes 4c..4c+3
    function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
        logic [127:0] n;
        logic [31:0] t;
        t[7:0]   = SBOX[k[111:104]] ^ rc;
        t[15:8]  = SBOX[k[119:112]];
        t[23:16] = SBOX[k[127:120]];
        t[31:24] = SBOX[k[103:96]];
        n[31:0]   = k[31:0] ^ t;
        n[63:32]  = k[63:32] ^ n[31:0];
        n[95:64]  = k[95:64] ^ n[63:32];
        n[127:96] = k[127:96] ^ n[95:64];
        return n;
    endfunction

    function automatic logic [7:0] rcon_first(input logic [3:0] r);
        logic [7:0] v;
        case (r)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

### design/xts_aes_sector_encrypt_top.sv
// XTS-AES-128 sector encryption with ciphertext stealing.
// Keys are written through the cfg port (index 0..3: tweak key high/low,
// data key high/low); the user must write them only while the block is idle, as the block does not enforce it.
// Input transactions on s_* carry one 16-byte plaintext block each; a block
// with first_block set starts a sector and encrypts its number for the tweak.
// Each transaction yields zero, one or two result transactions on m_*: the
// ciphertext of a block is held back until the next block arrives, so a short
// final block can steal from it.
// One shared iterative AES core, one round per clock, serves both the tweak
// and the data encryption; a first block runs the tweak encryption first, and
// an error result is given without any data encryption.
// Only one transaction is in work at a time; s_ready is high while idle.
// Results leave through an output register; while m_ready is low the
// controller waits before writing the next result, so nothing is lost.
// Reset clears the keys, tweak, held-block flag and sector state.
module xts_aes_sector_encrypt_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [xts_pkg::HalfWidth-1:0] cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [xts_pkg::HalfWidth-1:0] s_sector_number,
    input  logic                          s_first_block,
    input  logic [xts_pkg::HalfWidth-1:0] s_block_low,
    input  logic [xts_pkg::HalfWidth-1:0] s_block_high,
    input  logic [xts_pkg::CountWidth-1:0] s_valid_bytes,
    input  logic                          s_last_block,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [xts_pkg::HalfWidth-1:0] m_cipher_low,
    output logic [xts_pkg::HalfWidth-1:0] m_cipher_high,
    output logic [xts_pkg::CountWidth-1:0] m_cipher_bytes,
    output logic                          m_sector_end,
    output logic                          m_error
);
    import xts_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    assign cfg_ready = 1'b1;

    xts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .ctrl    (ctrl)
    );

    xts_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl            (ctrl),
        .status          (status),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_sector_number (s_sector_number),
        .s_first_block   (s_first_block),
        .s_block_low     (s_block_low),
        .s_block_high    (s_block_high),
        .s_valid_bytes   (s_valid_bytes),
        .s_last_block    (s_last_block),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cipher_low    (m_cipher_low),
        .m_cipher_high   (m_cipher_high),
        .m_cipher_bytes  (m_cipher_bytes),
        .m_sector_end    (m_sector_end),
        .m_error         (m_error)
    );

endmodule

### design/xts_aes_core.sv
module xts_aes_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [xts_pkg::BlockWidth-1:0] key,
    input  logic [xts_pkg::BlockWidth-1:0] block_in,
    output logic [xts_pkg::BlockWidth-1:0] block_out,
    output logic                       done
);
    import xts_pkg::*;

    logic [BlockWidth-1:0] state_reg, state_next;
    logic [BlockWidth-1:0] key_reg, key_next;
    logic [RoundWidth-1:0] round_reg, round_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [BlockWidth-1:0] round_key, sub_out;

    // one round per cycle, round key generated on the fly
    always_comb begin
        round_key  = next_key(key_reg, rcon_first(round_reg));
        sub_out    = sub_shift(state_reg);
        state_next = state_reg;
        key_next   = key_reg;
        round_next = round_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            state_next = block_in ^ key;
            key_next   = key;
            round_next = RoundWidth'(1);
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            key_next   = round_key;
            round_next = round_reg + RoundWidth'(1);
            if (round_reg == RoundWidth'(NumRounds)) begin
                state_next = sub_out ^ round_key;
                busy_next  = 1'b0;
                done_next  = 1'b1;
            end else begin
                state_next = mix_columns(sub_out) ^ round_key;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            round_reg <= round_next;
        end
        state_reg <= state_next;
        key_reg   <= key_next;
    end

    assign block_out = state_reg;
    assign done      = done_reg;

endmodule

### design/xts_datapath.sv
module xts_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  xts_pkg::ctrl_t                ctrl,
    output xts_pkg::status_t              status,
    input  logic                          cfg_valid,
    input  logic [1:0]                    cfg_index,
    input  logic [xts_pkg::HalfWidth-1:0] cfg_data,
    input  logic [xts_pkg::HalfWidth-1:0] s_sector_number,
    input  logic                          s_first_block,
    input  logic [xts_pkg::HalfWidth-1:0] s_block_low,
    input  logic [xts_pkg::HalfWidth-1:0] s_block_high,
    input  logic [xts_pkg::CountWidth-1:0] s_valid_bytes,
    input  logic                          s_last_block,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [xts_pkg::HalfWidth-1:0] m_cipher_low,
    output logic [xts_pkg::HalfWidth-1:0] m_cipher_high,
    output logic [xts_pkg::CountWidth-1:0] m_cipher_bytes,
    output logic                          m_sector_end,
    output logic                          m_error
);
    import xts_pkg::*;

    logic [HalfWidth-1:0]  tk_hi_reg, tk_lo_reg, dk_hi_reg, dk_lo_reg;
    logic [HalfWidth-1:0]  sn_reg;
    logic [BlockWidth-1:0] plain_reg, tweak_reg, held_reg, main_reg;
    logic [CountWidth-1:0] vb_reg;
    logic                  first_reg, last_reg;
    logic                  held_valid_reg, in_sector_reg;
    logic                  out_valid_reg;
    logic [HalfWidth-1:0]  out_lo_reg, out_hi_reg;
    logic [CountWidth-1:0] out_bytes_reg;
    logic                  out_end_reg, out_err_reg;
    logic [BlockWidth-1:0] core_key, core_in, core_out, stolen, tail, byte_keep, cipher;
    logic                  core_done, short_blk;
    logic [CountWidth-1:0] vb_fix;

    // key registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tk_hi_reg <= '0;
            tk_lo_reg <= '0;
            dk_hi_reg <= '0;
            dk_lo_reg <= '0;
        end else if (cfg_valid) begin
            case (reg_index_t'(cfg_index))
                REG_TWEAK_KEY_HIGH: tk_hi_reg <= cfg_data;
                REG_TWEAK_KEY_LOW:  tk_lo_reg <= cfg_data;
                REG_DATA_KEY_HIGH:  dk_hi_reg <= cfg_data;
                REG_DATA_KEY_LOW:   dk_lo_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // byte mask of the valid plaintext bytes
    always_comb begin
        vb_fix = (s_valid_bytes == '0 || s_valid_bytes > CountWidth'(FullBytes))
            ? CountWidth'(FullBytes) : s_valid_bytes;
        for (int j = 0; j < FullBytes; j++) begin
            byte_keep[8*j +: 8] = (CountWidth'(j) < vb_reg) ? ByteMask : 8'h00;
        end
    end

    assign short_blk = (vb_reg != CountWidth'(FullBytes));
    assign stolen    = (plain_reg & byte_keep) | (held_reg & ~byte_keep);
    assign tail      = held_reg & byte_keep;
    assign core_key  = ctrl.cipher_tweak ? {tk_hi_reg, tk_lo_reg} : {dk_hi_reg, dk_lo_reg};
    assign core_in   = ctrl.cipher_tweak ? {{HalfWidth{1'b0}}, sn_reg}
                                         : (stolen ^ tweak_reg);
    assign cipher    = core_out ^ tweak_reg;

    xts_aes_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (ctrl.cipher_tweak | ctrl.cipher_data),
        .key       (core_key),
        .block_in  (core_in),
        .block_out (core_out),
        .done      (core_done)
    );

    // item capture, fresh ciphertext and held block
    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            sn_reg    <= s_sector_number;
            plain_reg <= {s_block_high, s_block_low};
            vb_reg    <= vb_fix;
            first_reg <= s_first_block;
            last_reg  <= s_last_block;
        end
        if (ctrl.store_cipher) begin
            main_reg <= cipher;
        end
        if (ctrl.hold_main) begin
            held_reg <= main_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tweak_reg      <= '0;
            held_valid_reg <= 1'b0;
            in_sector_reg  <= 1'b0;
        end else begin
            if (ctrl.load_tweak) begin
                tweak_reg <= core_out;
            end else if (ctrl.store_cipher) begin
                tweak_reg <= {tweak_reg[BlockWidth-2:0], 1'b0}
                    ^ {{(BlockWidth-8){1'b0}}, (tweak_reg[BlockWidth-1] ? GfFeedback : 8'h00)};
            end
            if (ctrl.set_held) begin
                held_valid_reg <= 1'b1;
            end else if (ctrl.clr_held) begin
                held_valid_reg <= 1'b0;
            end
            if (ctrl.set_sector) begin
                in_sector_reg <= 1'b1;
            end else if (ctrl.clr_sector) begin
                in_sector_reg <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.out_held | ctrl.out_main | ctrl.out_tail | ctrl.out_error) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (ctrl.out_held) begin
            {out_hi_reg, out_lo_reg} <= held_reg;
            out_bytes_reg <= CountWidth'(FullBytes);
            out_end_reg   <= ctrl.out_held_end;
            out_err_reg   <= 1'b0;
        end else if (ctrl.out_main) begin
            {out_hi_reg, out_lo_reg} <= main_reg;
            out_bytes_reg <= CountWidth'(FullBytes);
            out_end_reg   <= ctrl.out_main_end;
            out_err_reg   <= 1'b0;
        end else if (ctrl.out_tail) begin
            {out_hi_reg, out_lo_reg} <= tail;
            out_bytes_reg <= vb_reg;
            out_end_reg   <= 1'b1;
            out_err_reg   <= 1'b0;
        end else if (ctrl.out_error) begin
            {out_hi_reg, out_lo_reg} <= '0;
            out_bytes_reg <= CountWidth'(FullBytes);
            out_end_reg   <= 1'b0;
            out_err_reg   <= 1'b1;
        end
    end

    assign status.cipher_done = core_done;
    assign status.out_busy    = out_valid_reg & ~m_ready;
    assign status.first       = first_reg;
    assign status.last        = last_reg;
    assign status.short_blk   = short_blk;
    assign status.held_valid  = held_valid_reg;
    assign status.in_sector   = in_sector_reg;

    assign m_valid        = out_valid_reg;
    assign m_cipher_low   = out_lo_reg;
    assign m_cipher_high  = out_hi_reg;
    assign m_cipher_bytes = out_bytes_reg;
    assign m_sector_end   = out_end_reg;
    assign m_error        = out_err_reg;

endmodule

### design/xts_ctrl.sv
module xts_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  xts_pkg::status_t status,
    output xts_pkg::ctrl_t   ctrl
);
    import xts_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_TWEAK_START;
            end
            ST_TWEAK_START: begin
                if (status.first) begin
                    if (status.held_valid) begin
                        if (!status.out_busy) state_next = ST_TWEAK_WAIT;
                    end else begin
                        state_next = ST_TWEAK_WAIT;
                    end
                end else if (!status.in_sector) begin
                    state_next = ST_EMIT_ERROR;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_TWEAK_WAIT: begin
                if (status.cipher_done) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (status.short_blk &&
                    (status.first || !status.last || !status.held_valid)) begin
                    state_next = ST_EMIT_ERROR;
                end else begin
                    state_next = ST_DATA_START;
                end
            end
            ST_DATA_START: state_next = ST_DATA_WAIT;
            ST_DATA_WAIT: begin
                if (status.cipher_done) begin
                    if (status.held_valid && !status.short_blk) state_next = ST_EMIT_HELD;
                    else if (status.last || status.short_blk) state_next = ST_EMIT_MAIN;
                    else state_next = ST_FINISH;
                end
            end
            ST_EMIT_HELD: begin
                if (!status.out_busy) begin
                    state_next = status.last ? ST_EMIT_MAIN : ST_FINISH;
                end
            end
            ST_EMIT_MAIN: begin
                if (!status.out_busy) state_next = status.short_blk ? ST_EMIT_TAIL : ST_FINISH;
            end
            ST_EMIT_TAIL: begin
                if (!status.out_busy) state_next = ST_FINISH;
            end
            ST_EMIT_ERROR: begin
                if (!status.out_busy) state_next = ST_FINISH;
            end
            ST_FINISH: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        ctrl    = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                ctrl.capture = s_valid;
            end
            ST_TWEAK_START: begin
                if (status.first) begin
                    if (status.held_valid) begin
                        if (!status.out_busy) begin
                            ctrl.out_held     = 1'b1;
                            ctrl.out_held_end = 1'b1;
                            ctrl.clr_held     = 1'b1;
                            ctrl.cipher_tweak = 1'b1;
                        end
                    end else begin
                        ctrl.cipher_tweak = 1'b1;
                    end
                end
            end
            ST_TWEAK_WAIT: begin
                if (status.cipher_done) begin
                    ctrl.load_tweak = 1'b1;
                    ctrl.set_sector = 1'b1;
                end
            end
            ST_CHECK: begin
                if (status.short_blk &&
                    (status.first || !status.last || !status.held_valid)) begin
                    ctrl.clr_held   = 1'b1;
                    ctrl.clr_sector = 1'b1;
                end
            end
            ST_DATA_START: ctrl.cipher_data = 1'b1;
            ST_DATA_WAIT: begin
                if (status.cipher_done) ctrl.store_cipher = 1'b1;
            end
            ST_EMIT_HELD: begin
                if (!status.out_busy) ctrl.out_held = 1'b1;
            end
            ST_EMIT_MAIN: begin
                if (!status.out_busy) begin
                    ctrl.out_main     = 1'b1;
                    ctrl.out_main_end = ~status.short_blk;
                end
            end
            ST_EMIT_TAIL: begin
                if (!status.out_busy) ctrl.out_tail = 1'b1;
            end
            ST_EMIT_ERROR: begin
                if (!status.out_busy) ctrl.out_error = 1'b1;
            end
            ST_FINISH: begin
                // settle held block and sector flags
                if (status.last || status.short_blk) begin
                    ctrl.clr_held   = 1'b1;
                    ctrl.clr_sector = status.in_sector;
                end else if (status.in_sector) begin
                    ctrl.hold_main = 1'b1;
                    ctrl.set_held  = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

### tb/xts_aes_sector_encrypt_top_test.sv
`timescale 1ns / 100ps

module xts_aes_sector_encrypt_top_test;
    import xts_pkg::*;

    typedef struct {
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  nbytes;
        logic        send;
        logic        err;
    } cipher_out_t;

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // aes-128 encryption, state byte i at bits 8i+7:8i, key likewise
    function automatic logic [127:0] aes128(input logic [127:0] key, input logic [127:0] pt);
        logic [7:0] sb [256];
        logic [7:0] rc [10];
        logic [127:0] s, t, k;
        logic [31:0] w;
        logic [7:0] a0, a1, a2, a3, al;
        sb = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        rc = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
        k = key;
        s = pt ^ k;
        for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[8*(4*c+i) +: 8] = sb[s[8*(4*((c+i)%4)+i) +: 8]];
            if (r != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[8*(4*c) +: 8];
                    a1 = t[8*(4*c+1) +: 8];
                    a2 = t[8*(4*c+2) +: 8];
                    a3 = t[8*(4*c+3) +: 8];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    t[8*(4*c) +: 8]   = a0 ^ al ^ xt(a0 ^ a1);
                    t[8*(4*c+1) +: 8] = a1 ^ al ^ xt(a1 ^ a2);
                    t[8*(4*c+2) +: 8] = a2 ^ al ^ xt(a2 ^ a3);
                    t[8*(4*c+3) +: 8] = a3 ^ al ^ xt(a3 ^ a0);
                end
            end
            // next round key: rotated, substituted last word
            w = {sb[k[103:96]], sb[k[127:120]], sb[k[119:112]], sb[k[111:104]] ^ rc[r-1]};
            k[31:0]   = k[31:0] ^ w;
            k[63:32]  = k[63:32] ^ k[31:0];
            k[95:64]  = k[95:64] ^ k[63:32];
            k[127:96] = k[127:96] ^ k[95:64];
            s = t ^ k;
        end
        return s;
    endfunction

    class sector_scoreboard;
        logic [127:0] tweak_key, data_key, tweak, held;
        bit held_valid, in_sector;
        cipher_out_t pending[$];
        int fails;

        function void reset_state();
            tweak_key = '0; data_key = '0; tweak = '0; held = '0;
            held_valid = 0; in_sector = 0; fails = 0;
        endfunction

        function void write_key(reg_index_t idx, logic [63:0] d);
            case (idx)
                REG_TWEAK_KEY_HIGH: tweak_key[127:64] = d;
                REG_TWEAK_KEY_LOW:  tweak_key[63:0] = d;
                REG_DATA_KEY_HIGH:  data_key[127:64] = d;
                REG_DATA_KEY_LOW:   data_key[63:0] = d;
                default: ;
            endcase
        endfunction

        function void push(logic [127:0] v, logic [4:0] n, bit e, bit err);
            cipher_out_t o;
            o.lo = v[63:0]; o.hi = v[127:64]; o.nbytes = n; o.send = e; o.err = err;
            pending.push_back(o);
        endfunction

        function logic [127:0] xts(logic [127:0] p);
            return aes128(data_key, p ^ tweak) ^ tweak;
        endfunction

        // predict the results of one accepted block
        function void note_block(logic [63:0] sn, bit first, logic [127:0] p,
                                 logic [4:0] vb, bit last);
            int v;
            logic [127:0] c, mask;
            v = (vb == 0 || vb > 16) ? 16 : vb;
            if (first) begin
                if (held_valid) begin
                    push(held, 16, 1, 0);
                    held_valid = 0;
                end
                tweak = aes128(tweak_key, {64'd0, sn});
                in_sector = 1;
            end else if (!in_sector) begin
                push('0, 16, 0, 1);
                return;
            end
            if (v < 16 && (first || !last || !held_valid)) begin
                held_valid = 0; in_sector = 0;
                push('0, 16, 0, 1);
                return;
            end
            if (v == 16) begin
                c = xts(p);
                tweak = {tweak[126:0], 1'b0} ^ (tweak[127] ? 128'h87 : 128'h0);
                if (held_valid) push(held, 16, 0, 0);
                if (last) begin
                    push(c, 16, 1, 0);
                    held_valid = 0; in_sector = 0;
                end else begin
                    held = c; held_valid = 1;
                end
                return;
            end
            // ciphertext stealing on a short final block
            mask = (128'd1 << (8 * v)) - 1;
            c = xts((p & mask) | (held & ~mask));
            push(c, 16, 0, 0);
            push(held & mask, v[4:0], 1, 0);
            held_valid = 0; in_sector = 0;
        endfunction

        function void check_result(cipher_out_t a);
            cipher_out_t e;
            if (pending.size() == 0) begin
                $error("unexpected result lo=%h hi=%h", a.lo, a.hi);
                fails++;
                return;
            end
            e = pending.pop_front();
            if (a.lo !== e.lo) begin
                $error("cipher_low exp %h got %h", e.lo, a.lo); fails++;
            end
            if (a.hi !== e.hi) begin
                $error("cipher_high exp %h got %h", e.hi, a.hi); fails++;
            end
            if (a.nbytes !== e.nbytes) begin
                $error("cipher_bytes exp %0d got %0d", e.nbytes, a.nbytes); fails++;
            end
            if (a.send !== e.send) begin
                $error("sector_end exp %0d got %0d", e.send, a.send); fails++;
            end
            if (a.err !== e.err) begin
                $error("error exp %0d got %0d", e.err, a.err); fails++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_valid = 0, cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic s_valid = 0, s_ready;
    logic [63:0] s_sector_number = '0, s_block_low = '0, s_block_high = '0;
    logic s_first_block = 0, s_last_block = 0;
    logic [4:0] s_valid_bytes = 5'd16;
    logic m_valid, m_ready = 0;
    logic [63:0] m_cipher_low, m_cipher_high;
    logic [4:0] m_cipher_bytes;
    logic m_sector_end, m_error;

    sector_scoreboard sb = new();
    bit stim_done = 0;

    xts_aes_sector_encrypt_top DUT (.*);

    always #2 aclk = ~aclk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random stalls and checking at the rising edge
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            n = gap_len();
            if (n > 0) begin
                m_ready <= 0;
                repeat (n) @(negedge aclk);
            end
            m_ready <= 1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            sb.check_result('{m_cipher_low, m_cipher_high, m_cipher_bytes, m_sector_end, m_error});
        end
    end

    task automatic write_reg(reg_index_t idx, logic [63:0] d);
        cfg_index <= idx;
        cfg_data <= d;
        cfg_valid <= 1;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_key(idx, d);
        @(negedge aclk);
    endtask

    task automatic send_block(logic [63:0] sn, bit first, logic [127:0] p,
                              logic [4:0] vb, bit last);
        int n;
        n = gap_len();
        if (n > 0) begin
            s_valid <= 0;
            repeat (n) @(negedge aclk);
        end
        s_sector_number <= sn; s_first_block <= first;
        s_block_low <= p[63:0]; s_block_high <= p[127:64];
        s_valid_bytes <= vb; s_last_block <= last;
        s_valid <= 1;
        do @(posedge aclk); while (!s_ready);
        sb.note_block(sn, first, p, vb, last);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic set_keys(logic [63:0] a, logic [63:0] b, logic [63:0] c, logic [63:0] d);
        write_reg(REG_TWEAK_KEY_HIGH, a);
        write_reg(REG_TWEAK_KEY_LOW, b);
        write_reg(REG_DATA_KEY_HIGH, c);
        write_reg(REG_DATA_KEY_LOW, d);
        cfg_valid <= 0;
    endtask

    function automatic logic [127:0] rand_blk();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // one well-formed sector of random length, sometimes with a stolen tail
    task automatic random_sector(output int cnt);
        int len;
        logic [63:0] sn;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
        sn = ($urandom_range(0, 3) == 0) ? ~64'd0 : {$urandom, $urandom};
        cnt = 0;
        for (int i = 0; i < len; i++) begin
            bit lst;
            logic [4:0] vb;
            lst = (i == len - 1) && ($urandom_range(0, 4) != 0);
            vb = 16;
            if (lst && i > 0 && $urandom_range(0, 1)) vb = $urandom_range(1, 15);
            send_block(sn, i == 0, rand_blk(), vb, lst);
            cnt++;
        end
    endtask

    initial begin
        int total, c;
        sb.reset_state();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed part under reset keys then extreme keys
        send_block(64'd5, 0, '0, 16, 0);
        send_block(64'd0, 1, '0, 16, 1);
        drain();
        set_keys(~64'd0, ~64'd0, ~64'd0, ~64'd0);
        send_block(~64'd0, 1, ~128'd0, 16, 0);
        send_block(64'd0, 0, '0, 1, 1);
        send_block(64'd1, 1, rand_blk(), 16, 0);
        send_block(64'd0, 0, rand_blk(), 15, 1);
        send_block(64'd2, 1, rand_blk(), 16, 0);
        send_block(64'd0, 0, rand_blk(), 16, 0);
        send_block(64'd3, 1, rand_blk(), 16, 0);
        send_block(64'd0, 0, rand_blk(), 8, 0);
        send_block(64'd4, 1, rand_blk(), 7, 1);
        send_block(64'd6, 1, rand_blk(), 5, 1);
        send_block(64'd0, 0, rand_blk(), 0, 0);
        send_block(64'd7, 1, rand_blk(), 16, 0);
        send_block(64'd0, 0, rand_blk(), 31, 1);
        send_block(64'h8000_0000_0000_0000, 1, rand_blk(), 16, 0);
        send_block(64'd0, 0, rand_blk(), 9, 1);
        drain();
        set_keys('0, '0, '0, '0);
        send_block(64'd9, 1, rand_blk(), 16, 0);
        send_block(64'd0, 0, rand_blk(), 16, 1);
        drain();

        // random sectors and stray single blocks, keys changed between phases
        total = 0;
        for (int ph = 0; ph < 5; ph++) begin
            set_keys({$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
            while (total < 210 * (ph + 1)) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_block({$urandom, $urandom}, $urandom_range(0, 1), rand_blk(),
                               $urandom_range(0, 31), $urandom_range(0, 1));
                    total++;
                end else begin
                    random_sector(c);
                    total += c;
                end
            end
            drain();
        end
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        if (sb.fails == 0 && sb.pending.size() == 0)
            $display("xts_aes_sector_encrypt_top_test: PASS");
        else
            $display("xts_aes_sector_encrypt_top_test: FAIL");
        $finish;
    end

    initial begin
        #4000000;
        $display("xts_aes_sector_encrypt_top_test: FAIL");
        $finish;
    end
endmodule
